// ----- rtl/uint128_alu_assert.svh -----
// assertion macros for the uint128_alu block
// expects signals named clk and rst_n in the including module
`ifndef UINT128_ALU_ASSERT_SVH
`define UINT128_ALU_ASSERT_SVH

`ifndef NO_ASSERTIONS

// checked only out of reset
`define U128_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("uint128_alu assertion failed");

// checked in and out of reset
`define U128_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("uint128_alu reset assertion failed");

`else

`define U128_ASSERT(lbl, prop)
`define U128_ASSERT_RST(lbl, prop)

`endif

`endif

// ----- rtl/u128alu_pkg.sv -----
// shared types and constants for the uint128_alu block
// no dependencies
`timescale 1ns / 1ps

package u128alu_pkg;

  localparam int HALF_W      = 64;
  localparam int DATA_W      = 2 * HALF_W;
  localparam int SHIFT_W     = 7;
  localparam int FUNC_W      = 4;
  localparam int CNT_W       = 7;
  localparam int IN_FIELDS_W = FUNC_W + 2 * DATA_W + SHIFT_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = DATA_W;

  // tdata bit offsets of the input fields
  localparam int IN_FUNC_LSB  = 0;
  localparam int IN_AHI_LSB   = IN_FUNC_LSB + FUNC_W;
  localparam int IN_ALO_LSB   = IN_AHI_LSB + HALF_W;
  localparam int IN_BHI_LSB   = IN_ALO_LSB + HALF_W;
  localparam int IN_BLO_LSB   = IN_BHI_LSB + HALF_W;
  localparam int IN_SHIFT_LSB = IN_BLO_LSB + HALF_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD = 4'd0,
    FN_SUB = 4'd1,
    FN_MUL = 4'd2,
    FN_DIV = 4'd3,
    FN_MOD = 4'd4,
    FN_AND = 4'd5,
    FN_OR  = 4'd6,
    FN_XOR = 4'd7,
    FN_SHL = 4'd8,
    FN_SHR = 4'd9
  } func_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic ready;  // idle, taking a new word
    logic load;   // input word accepted this cycle
    logic step;   // one multiply or divide iteration
    logic fin;    // result is being finished
  } ctl_t;

endpackage

// ----- rtl/u128alu_addsub.sv -----
// shared 129-bit add / subtract unit of the uint128_alu block
// depends on u128alu_pkg
`timescale 1ns / 1ps

module u128alu_addsub (
  input  logic [u128alu_pkg::DATA_W:0] x,
  input  logic [u128alu_pkg::DATA_W:0] y,
  input  logic                         sub,
  output logic [u128alu_pkg::DATA_W:0] sum,
  output logic                         cout
);

  logic [u128alu_pkg::DATA_W+1:0] full;
  logic [u128alu_pkg::DATA_W:0]   y_inv;

  assign y_inv = y ^ {(u128alu_pkg::DATA_W + 1){sub}};
  assign full  = {1'b0, x} + {1'b0, y_inv}
               + {{(u128alu_pkg::DATA_W + 1){1'b0}}, sub};
  assign sum   = full[u128alu_pkg::DATA_W:0];
  // for subtract, carry out set means x >= y
  assign cout  = full[u128alu_pkg::DATA_W+1];

endmodule

// ----- rtl/u128alu_seq.sv -----
// sequencer of the uint128_alu block: idle, iterate, finish
// depends on u128alu_pkg
`timescale 1ns / 1ps

module u128alu_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                iter,
  input  logic                out_free,
  output u128alu_pkg::ctl_t   ctl
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_FIN  = 3'b100
  } st_t;

  st_t                          st_r, st_nxt;
  logic [u128alu_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    ctl.ready = 1'b0;
    ctl.load  = 1'b0;
    ctl.step  = 1'b0;
    ctl.fin   = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        ctl.ready = 1'b1;
        ctl.load  = in_valid;
        cnt_nxt   = '0;
        if (in_valid) begin
          st_nxt = iter ? ST_RUN : ST_FIN;
        end
      end
      ST_RUN: begin
        ctl.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          st_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        ctl.fin = 1'b1;
        if (out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      cnt_r <= '0;
    end else begin
      st_r  <= st_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/uint128_alu.sv -----
// top level of the uint128_alu block: unsigned 128-bit alu with divide
// depends on u128alu_pkg, u128alu_addsub, u128alu_seq, uint128_alu_assert.svh
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------
//  in_     | in  | in_tvalid/tready   | func, a_high, a_low, b_high, b_low, sh
//  out_    | out | out_tvalid/tready  | result_high, result_low; tuser div0
//
// mul, div and mod: an accept step, 128 iterations of the shared adder
// (one bit per cycle), then a finish step
// add, sub, logic ops, shifts and divide by zero: an accept step and a finish step
// the sequencer's 7-bit counter sets the iteration count
// rst_n is synchronous, active low; clears the sequencer and out_tvalid
// a stalled output holds the finish step; the next word waits until it moves
`timescale 1ns / 1ps
`include "uint128_alu_assert.svh"

module uint128_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // func [3:0], a_high [67:4], a_low [131:68], b_high [195:132],
  // b_low [259:196], shift_amount [266:260], zero fill above
  input  logic [u128alu_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // result_high [63:0], result_low [127:64]
  output logic [u128alu_pkg::OUT_TDATA_W-1:0] out_tdata,
  // divide_by_zero [0]
  output logic [0:0]                          out_tuser
);

  localparam int DW = u128alu_pkg::DATA_W;
  localparam int HW = u128alu_pkg::HALF_W;

  u128alu_pkg::ctl_t ctl;

  // unpacked input fields
  u128alu_pkg::func_t                in_func;
  logic [DW-1:0]                     in_a, in_b;
  logic [u128alu_pkg::SHIFT_W-1:0]   in_sh;
  logic                              in_b_zero, in_divmod, in_iter;

  // working registers
  u128alu_pkg::func_t              func_r;
  logic [DW-1:0]                   a_r, b_r, acc_r;
  logic [u128alu_pkg::SHIFT_W-1:0] sh_r;
  logic                            dz_r;

  // shared adder
  logic [DW:0] add_x, add_y, add_sum;
  logic        add_sub, add_cout;

  logic [DW-1:0] res;
  logic          out_free;

  logic                              out_tvalid_r;
  logic [u128alu_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                              out_tuser_r;

  assign in_func = u128alu_pkg::func_t'(
    in_tdata[u128alu_pkg::IN_FUNC_LSB +: u128alu_pkg::FUNC_W]);
  assign in_a  = {in_tdata[u128alu_pkg::IN_AHI_LSB +: HW],
                  in_tdata[u128alu_pkg::IN_ALO_LSB +: HW]};
  assign in_b  = {in_tdata[u128alu_pkg::IN_BHI_LSB +: HW],
                  in_tdata[u128alu_pkg::IN_BLO_LSB +: HW]};
  assign in_sh = in_tdata[u128alu_pkg::IN_SHIFT_LSB +: u128alu_pkg::SHIFT_W];

  assign in_b_zero  = (in_b == '0);
  assign in_divmod  = (in_func == u128alu_pkg::FN_DIV) ||
                      (in_func == u128alu_pkg::FN_MOD);
  // multiply always iterates, div/mod only with a nonzero divisor
  assign in_iter    = (in_func == u128alu_pkg::FN_MUL) || (in_divmod && !in_b_zero);

  assign out_free = !out_tvalid_r || out_tready;

  u128alu_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .iter     (in_iter),
    .out_free (out_free),
    .ctl      (ctl)
  );

  assign in_tready = ctl.ready;

  // adder operand selection
  always_comb begin
    case (func_r) inside
      u128alu_pkg::FN_MUL: begin
        // shift-add: add the shifted multiplicand when the low multiplier bit is set
        add_x   = {1'b0, acc_r};
        add_y   = {1'b0, (b_r[0] ? a_r : '0)};
        add_sub = 1'b0;
      end
      u128alu_pkg::FN_DIV, u128alu_pkg::FN_MOD: begin
        // restoring step: partial remainder with next dividend bit, minus divisor
        add_x   = {acc_r, a_r[DW-1]};
        add_y   = {1'b0, b_r};
        add_sub = 1'b1;
      end
      u128alu_pkg::FN_SUB: begin
        add_x   = {1'b0, a_r};
        add_y   = {1'b0, b_r};
        add_sub = 1'b1;
      end
      default: begin
        add_x   = {1'b0, a_r};
        add_y   = {1'b0, b_r};
        add_sub = 1'b0;
      end
    endcase
  end

  u128alu_addsub u_addsub (
    .x    (add_x),
    .y    (add_y),
    .sub  (add_sub),
    .sum  (add_sum),
    .cout (add_cout)
  );

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func_r <= in_func;
      a_r    <= in_a;
      b_r    <= in_b;
      sh_r   <= in_sh;
      acc_r  <= '0;
      dz_r   <= in_divmod && in_b_zero;
    end else if (ctl.step) begin
      if (func_r == u128alu_pkg::FN_MUL) begin
        acc_r <= add_sum[DW-1:0];
        a_r   <= {a_r[DW-2:0], 1'b0};
        b_r   <= {1'b0, b_r[DW-1:1]};
      end else begin
        // carry out set: partial remainder >= divisor, keep the difference
        acc_r <= add_cout ? add_sum[DW-1:0] : {acc_r[DW-2:0], a_r[DW-1]};
        a_r   <= {a_r[DW-2:0], add_cout};
      end
    end
  end

  // final result select
  always_comb begin
    case (func_r) inside
      u128alu_pkg::FN_ADD, u128alu_pkg::FN_SUB: res = add_sum[DW-1:0];
      u128alu_pkg::FN_MUL: res = acc_r;
      u128alu_pkg::FN_DIV: res = dz_r ? '0 : a_r;   // quotient shifted in
      u128alu_pkg::FN_MOD: res = dz_r ? '0 : acc_r; // remainder
      u128alu_pkg::FN_AND: res = a_r & b_r;
      u128alu_pkg::FN_OR:  res = a_r | b_r;
      u128alu_pkg::FN_XOR: res = a_r ^ b_r;
      u128alu_pkg::FN_SHL: res = a_r << sh_r;
      u128alu_pkg::FN_SHR: res = a_r >> sh_r;
      default:             res = '0;                // unused codes
    endcase
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (ctl.fin && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.fin && out_free) begin
      out_tdata_r <= {res[HW-1:0], res[DW-1:HW]};
      out_tuser_r <= dz_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // a finish step with room always produces a word next cycle
  `U128_ASSERT(a_fin_out, (ctl.fin && out_free) |=> out_tvalid)
  // divide by zero always comes with a zero result
  `U128_ASSERT(a_dz_zero, (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
  // no word is taken while iterating
  `U128_ASSERT(a_busy_step, ctl.step |-> (!in_tready && !ctl.load))
  // reset empties the output register
  `U128_ASSERT_RST(a_rst_out, !rst_n |=> !out_tvalid)

endmodule
